### hw/rtl/polyphase_iir_halfband_filter_core_defines.svh
// assertion macros for the polyphase iir half-band filter core
// no dependencies; included by the files that carry assertions
`ifndef POLYPHASE_IIR_HALFBAND_FILTER_CORE_DEFINES_SVH
`define POLYPHASE_IIR_HALFBAND_FILTER_CORE_DEFINES_SVH

// checked only outside reset
`define PHF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PHF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/phf_pkg.sv
// shared constants, types and coefficient rom of the polyphase iir half-band filter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package phf_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int STATE_BITS     = 28;
   localparam int COEF_BITS      = 18;
   localparam int MAX_STAGES     = 6;
   localparam int NUM_ORDERS     = 6;
   localparam int NUM_PATHS      = 2;
   localparam int SEC_BITS       = $clog2(MAX_STAGES + 1);
   localparam int HIST_DEPTH     = NUM_PATHS * MAX_STAGES;
   localparam int HIST_ADDR_BITS = $clog2(HIST_DEPTH);
   localparam int ORD_BITS       = 4;
   localparam int ORD_IDX_BITS   = $clog2(NUM_ORDERS);
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_ORDER = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEEP_MODE   = CSR_INDEX_BITS'(1);

   localparam logic [ORD_BITS-1:0] ORDER_RESET = ORD_BITS'(12);
   localparam logic                STEEP_RESET = 1'b1;

   localparam logic PATH_A = 1'b0;
   localparam logic PATH_B = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [STATE_BITS-1:0]  state_type;
   typedef logic [COEF_BITS-1:0]          coef_type;
   typedef logic [SEC_BITS-1:0]           sec_type;
   typedef logic [ORD_BITS-1:0]           order_type;
   typedef logic [ORD_IDX_BITS-1:0]       ord_idx_type;
   typedef logic [HIST_ADDR_BITS-1:0]     hist_addr_type;

   typedef struct packed {
      state_type n1;
      state_type n2;
   } hist_pair_type;

   typedef struct packed {
      logic          clear;
      logic          wr;
      hist_addr_type addr;
   } hist_ctl_type;

   typedef struct packed {
      logic load;
      logic mul;
   } alu_ctl_type;

   localparam real COEF_SCALE = real'(64'd1 << COEF_BITS);

   // round half up of a fraction into unsigned q0.COEF_BITS
   function automatic coef_type to_coef(input real v);
      return coef_type'($rtoi(v * COEF_SCALE + 0.5));
   endfunction

   // table index for an order value; unlisted orders fall back to order 2
   function automatic ord_idx_type order_index(input order_type ord);
      ord_idx_type idx;
      unique case (ord)
         ORD_BITS'(4):  idx = ORD_IDX_BITS'(1);
         ORD_BITS'(6):  idx = ORD_IDX_BITS'(2);
         ORD_BITS'(8):  idx = ORD_IDX_BITS'(3);
         ORD_BITS'(10): idx = ORD_IDX_BITS'(4);
         ORD_BITS'(12): idx = ORD_IDX_BITS'(5);
         default:       idx = ORD_IDX_BITS'(0);
      endcase
      return idx;
   endfunction

   function automatic sec_type stage_count(input ord_idx_type idx);
      sec_type n;
      n = SEC_BITS'(idx) + SEC_BITS'(1);
      if (n > SEC_BITS'(MAX_STAGES)) begin
         n = SEC_BITS'(MAX_STAGES);
      end
      return n;
   endfunction

   localparam coef_type CZ = '0;

   // [steep][order index][path][section]
   localparam coef_type COEF_ROM [2][NUM_ORDERS][NUM_PATHS][MAX_STAGES] = '{
      '{ // soft
         '{'{to_coef(0.23647102099689224), CZ, CZ, CZ, CZ, CZ},
           '{to_coef(0.7145421497126001), CZ, CZ, CZ, CZ, CZ}},
         '{'{to_coef(0.07986642623635751), to_coef(0.5453536510711322), CZ, CZ, CZ, CZ},
           '{to_coef(0.28382934487410993), to_coef(0.8344118914807379), CZ, CZ, CZ, CZ}},
         '{'{to_coef(0.06029739095712437), to_coef(0.4125907203610563),
             to_coef(0.7727156537429234), CZ, CZ, CZ},
           '{to_coef(0.21597144456092948), to_coef(0.6043586264658363),
             to_coef(0.9238861386532906), CZ, CZ, CZ}},
         '{'{to_coef(0.03583278843106211), to_coef(0.2720401433964576),
             to_coef(0.5720571972357003), to_coef(0.827124761997324), CZ, CZ},
           '{to_coef(0.1340901419430669), to_coef(0.4243248712718685),
             to_coef(0.7062921421386394), to_coef(0.9415030941737551), CZ, CZ}},
         '{'{to_coef(0.02366831419883467), to_coef(0.18989476227180174),
             to_coef(0.43157318062118555), to_coef(0.6632020224193995),
             to_coef(0.860015542499582), CZ},
           '{to_coef(0.09056555904993387), to_coef(0.3078575723749043),
             to_coef(0.5516782402507934), to_coef(0.7652146863779808),
             to_coef(0.95247728378667541), CZ}},
         '{'{to_coef(0.01677466677723562), to_coef(0.13902148819717805),
             to_coef(0.3325011117394731), to_coef(0.53766105314488),
             to_coef(0.7214184024215805), to_coef(0.8821858402078155)},
           '{to_coef(0.06501319274445962), to_coef(0.23094129990840923),
             to_coef(0.4364942348420355), to_coef(0.06329609551399348),
             to_coef(0.80378086794111226), to_coef(0.9599687404800694)}}
      },
      '{ // steep
         '{'{to_coef(0.23647102099689224), CZ, CZ, CZ, CZ, CZ},
           '{to_coef(0.7145421497126001), CZ, CZ, CZ, CZ, CZ}},
         '{'{to_coef(0.12073211751675449), to_coef(0.6632020224193995), CZ, CZ, CZ, CZ},
           '{to_coef(0.3903621872345006), to_coef(0.890786832653497), CZ, CZ, CZ, CZ}},
         '{'{to_coef(0.1271414136264853), to_coef(0.6528245886369117),
             to_coef(0.9176942834328115), CZ, CZ, CZ},
           '{to_coef(0.40056789819445626), to_coef(0.8204163891923343),
             to_coef(0.9763114515836773), CZ, CZ, CZ}},
         '{'{to_coef(0.07711507983241622), to_coef(0.4820706250610472),
             to_coef(0.7968204713315797), to_coef(0.9412514277740471), CZ, CZ},
           '{to_coef(0.2659685265210946), to_coef(0.6651041532634957),
             to_coef(0.8841015085506159), to_coef(0.9820054141886075), CZ, CZ}},
         '{'{to_coef(0.051457617441190984), to_coef(0.35978656070567017),
             to_coef(0.6725475931034693), to_coef(0.8590884928249939),
             to_coef(0.9540209867860787), CZ},
           '{to_coef(0.18621906251989334), to_coef(0.529951372847964),
             to_coef(0.7810257527489514), to_coef(0.9141815687605308),
             to_coef(0.985475023014907), CZ}},
         '{'{to_coef(0.036681502163648017), to_coef(0.2746317593794541),
             to_coef(0.56109896978791948), to_coef(0.769741833862266),
             to_coef(0.8922608180038789), to_coef(0.962094548378084)},
           '{to_coef(0.13654762463195771), to_coef(0.42313861743656667),
             to_coef(0.6775400499741616), to_coef(0.839889624849638),
             to_coef(0.9315419599631839), to_coef(0.9878163707328971)}}
      }
   };

endpackage

### hw/rtl/phf_history.sv
// allpass section history: x[n-1], x[n-2], y[n-1], y[n-2] per section of both paths
// depends on phf_pkg
`timescale 1ns / 1ps

module phf_history
   import phf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hist_ctl_type ctl,
   input  state_type    x_wr,
   input  state_type    y_wr,
   output state_type    x2,
   output state_type    y2
);

   hist_pair_type in_hist_ff  [HIST_DEPTH];
   hist_pair_type out_hist_ff [HIST_DEPTH];

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            in_hist_ff[i]  <= '0;
            out_hist_ff[i] <= '0;
         end
      end else if (ctl.wr) begin
         in_hist_ff[ctl.addr]  <= '{n1: x_wr, n2: in_hist_ff[ctl.addr].n1};
         out_hist_ff[ctl.addr] <= '{n1: y_wr, n2: out_hist_ff[ctl.addr].n1};
      end
   end

   assign x2 = in_hist_ff[ctl.addr].n2;
   assign y2 = out_hist_ff[ctl.addr].n2;

endmodule

### hw/rtl/phf_section_unit.sv
// shared allpass section datapath: difference, coefficient multiply, round, add, saturate
// depends on phf_pkg
`timescale 1ns / 1ps

module phf_section_unit
   import phf_pkg::*;
(
   input  logic        clock,
   input  alu_ctl_type ctl,
   input  state_type   x,
   input  state_type   x2,
   input  state_type   y2,
   input  coef_type    coef,
   output state_type   y
);

   localparam int DIFF_BITS = STATE_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + COEF_BITS + 1;
   localparam int P_BITS    = PROD_BITS - COEF_BITS;
   localparam int SUM_BITS  = P_BITS + 1;

   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) <<< (COEF_BITS - 1);
   localparam logic signed [SUM_BITS-1:0]  STATE_MAX  =
      SUM_BITS'((64'sd1 <<< (STATE_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_BITS-1:0]  STATE_MIN  = -STATE_MAX - SUM_BITS'(1);

   logic signed [DIFF_BITS-1:0] diff_ff;
   state_type                   x2_ff;
   coef_type                    coef_ff;
   logic signed [PROD_BITS-1:0] prod_ff;

   logic signed [COEF_BITS:0]   coef_s;
   logic signed [PROD_BITS-1:0] prod;
   logic signed [PROD_BITS-1:0] rounded;
   logic signed [P_BITS-1:0]    p;
   logic signed [SUM_BITS-1:0]  sum;

   assign coef_s  = $signed({1'b0, coef_ff});
   assign prod    = diff_ff * coef_s;
   assign rounded = prod_ff + ROUND_HALF;
   assign p       = rounded[PROD_BITS-1:COEF_BITS];
   assign sum     = SUM_BITS'(x2_ff) + SUM_BITS'(p);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         diff_ff <= DIFF_BITS'(x) - DIFF_BITS'(y2);
         x2_ff   <= x2;
         coef_ff <= coef;
      end
      if (ctl.mul) begin
         prod_ff <= prod;
      end
   end

   always_comb begin
      priority if (sum > STATE_MAX) begin
         y = STATE_MAX[STATE_BITS-1:0];
      end else if (sum < STATE_MIN) begin
         y = STATE_MIN[STATE_BITS-1:0];
      end else begin
         y = sum[STATE_BITS-1:0];
      end
   end

endmodule

### hw/rtl/polyphase_iir_halfband_filter_core.sv
// top level of the polyphase iir half-band filter: sequencer, config registers, output
// depends on phf_pkg, phf_history, phf_section_unit and the defines header
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    req_sample_in (24b signed)
//   rsp       out   rsp_valid/rsp_ready    rsp_sample_out (24b signed)
//   csr       in    csr_valid/csr_ready    csr_index, csr_data
//
// each section steps through ST_RD, ST_MUL and ST_WB on the one shared multiply unit (diff, multiply, round/add)
// an item runs 2*n sections for n sections per path, six per path at order 12
// reset is synchronous: order 12, steep set, history cleared in the same cycle
// any csr transfer to a listed register clears all history at once
// the next item is taken while a finished result waits in the output register
`timescale 1ns / 1ps
`include "polyphase_iir_halfband_filter_core_defines.svh"

module polyphase_iir_halfband_filter_core
   import phf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sample_type                req_sample_in,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sample_type                rsp_sample_out,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_WB   = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam int HALF_BITS = STATE_BITS + 1;
   localparam logic signed [STATE_BITS-1:0] SAMPLE_MAX =
      STATE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [STATE_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - STATE_BITS'(1);

   logic [2:0]  state_ff, state_in;
   order_type   order_ff, order_in;
   logic        steep_ff, steep_in;
   ord_idx_type oidx_ff, oidx_in;
   sec_type     stages_ff, stages_in;
   logic        path_ff, path_in;
   sec_type     sec_ff, sec_in;
   state_type   x_ff, x_in;
   state_type   xin_ff, xin_in;
   state_type   aout_ff, aout_in;
   state_type   dlyb_ff, dlyb_in;
   sample_type  res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sample_type  rsp_sample_ff, rsp_sample_in;

   logic         req_xfer, rsp_xfer, csr_xfer, csr_hit;
   hist_ctl_type hist_ctl;
   alu_ctl_type  alu_ctl;
   state_type    hist_x2, hist_y2, sec_y;
   coef_type     coef;
   logic         last_sec;
   logic signed [HALF_BITS-1:0] out_sum;
   state_type    out_half;
   sample_type   out_sat;

   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign csr_xfer  = csr_valid && csr_ready;
   assign csr_hit   = csr_xfer &&
                      ((csr_index == REG_FILTER_ORDER) || (csr_index == REG_STEEP_MODE));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   assign coef     = COEF_ROM[steep_ff][oidx_ff][path_ff][sec_ff];
   assign last_sec = (sec_ff + SEC_BITS'(1)) == stages_ff;

   assign hist_ctl.clear = csr_hit;
   assign hist_ctl.wr    = (state_ff == ST_WB);
   assign hist_ctl.addr  = (path_ff == PATH_B)
                           ? HIST_ADDR_BITS'(MAX_STAGES) + HIST_ADDR_BITS'(sec_ff)
                           : HIST_ADDR_BITS'(sec_ff);

   assign alu_ctl.load = (state_ff == ST_RD);
   assign alu_ctl.mul  = (state_ff == ST_MUL);

   // (a + delayed b + 1) >> 1, then clip to the sample range
   assign out_sum  = HALF_BITS'(aout_ff) + HALF_BITS'(dlyb_ff) + HALF_BITS'(1);
   assign out_half = out_sum[HALF_BITS-1:1];

   always_comb begin
      priority if (out_half > SAMPLE_MAX) begin
         out_sat = SAMPLE_MAX[SAMPLE_BITS-1:0];
      end else if (out_half < SAMPLE_MIN) begin
         out_sat = SAMPLE_MIN[SAMPLE_BITS-1:0];
      end else begin
         out_sat = out_half[SAMPLE_BITS-1:0];
      end
   end

   phf_history u_history (
      .clock (clock),
      .reset (reset),
      .ctl   (hist_ctl),
      .x_wr  (x_ff),
      .y_wr  (sec_y),
      .x2    (hist_x2),
      .y2    (hist_y2)
   );

   phf_section_unit u_section (
      .clock (clock),
      .ctl   (alu_ctl),
      .x     (x_ff),
      .x2    (hist_x2),
      .y2    (hist_y2),
      .coef  (coef),
      .y     (sec_y)
   );

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      steep_in      = steep_ff;
      oidx_in       = oidx_ff;
      stages_in     = stages_ff;
      path_in       = path_ff;
      sec_in        = sec_ff;
      x_in          = x_ff;
      xin_in        = xin_ff;
      aout_in       = aout_ff;
      dlyb_in       = dlyb_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_xfer) begin
         unique case (csr_index)
            REG_FILTER_ORDER: order_in = csr_data[ORD_BITS-1:0];
            REG_STEEP_MODE:   steep_in = csr_data[0];
            default: ;
         endcase
      end
      if (csr_hit) begin
         dlyb_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               oidx_in   = order_index(order_ff);
               stages_in = stage_count(order_index(order_ff));
               path_in   = PATH_A;
               sec_in    = '0;
               x_in      = STATE_BITS'(req_sample_in);
               xin_in    = STATE_BITS'(req_sample_in);
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            x_in = sec_y;
            if (!last_sec) begin
               sec_in   = sec_ff + SEC_BITS'(1);
               state_in = ST_RD;
            end else if (path_ff == PATH_A) begin
               aout_in  = sec_y;
               path_in  = PATH_B;
               sec_in   = '0;
               x_in     = xin_ff;
               state_in = ST_RD;
            end else begin
               res_in   = out_sat;
               dlyb_in  = sec_y;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= ORDER_RESET;
         steep_ff     <= STEEP_RESET;
         dlyb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         order_ff     <= order_in;
         steep_ff     <= steep_in;
         dlyb_ff      <= dlyb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      oidx_ff       <= oidx_in;
      stages_ff     <= stages_in;
      path_ff       <= path_in;
      sec_ff        <= sec_in;
      x_ff          <= x_in;
      xin_ff        <= xin_in;
      aout_ff       <= aout_in;
      res_ff        <= res_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   `PHF_ASSERT(a_ready_only_idle, clock, reset, !(req_ready && (state_ff != ST_IDLE)), "req_ready outside idle")
   `PHF_ASSERT(a_busy_after_accept, clock, reset, req_xfer |=> (state_ff == ST_RD), "accepted item did not start")
   `PHF_ASSERT(a_wb_after_mul, clock, reset, (state_ff == ST_WB) |-> ($past(state_ff) == ST_MUL), "write-back without multiply")
   `PHF_ASSERT(a_sec_in_range, clock, reset, ((state_ff == ST_RD) || (state_ff == ST_MUL) || (state_ff == ST_WB)) |-> (sec_ff < stages_ff), "section index past stage count")
   `PHF_ASSERT(a_done_on_path_b, clock, reset, (state_ff == ST_DONE) |-> (path_ff == PATH_B), "result before path b ran")

endmodule

### dv/halfband_output_checker.sv
// output checker for the polyphase iir half-band filter core: watches all three channels,
// predicts each filtered sample in fixed point and compares it against the rsp transfer
// depends on phf_pkg for field types, widths and register indexes
`timescale 1ns / 1ps

module halfband_output_checker
   import phf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  sample_type                req_sample_in,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sample_type                rsp_sample_out,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        mismatch_count,
   output int                        pending_samples
);

   localparam longint unsigned DECIMAL_ONE = 64'd1000000000000000000;
   localparam int FRAC_DIGITS = 18;
   localparam int TABLE_SIZE = 2 * NUM_ORDERS * NUM_PATHS * MAX_STAGES;

   // decimal coefficients: [steep][order row][path][section], flattened
   string coef_text [TABLE_SIZE] = '{
      "0.23647102099689224", "", "", "", "", "",
      "0.7145421497126001", "", "", "", "", "",
      "0.07986642623635751", "0.5453536510711322", "", "", "", "",
      "0.28382934487410993", "0.8344118914807379", "", "", "", "",
      "0.06029739095712437", "0.4125907203610563", "0.7727156537429234",
      "", "", "",
      "0.21597144456092948", "0.6043586264658363", "0.9238861386532906",
      "", "", "",
      "0.03583278843106211", "0.2720401433964576", "0.5720571972357003",
      "0.827124761997324", "", "",
      "0.1340901419430669", "0.4243248712718685", "0.7062921421386394",
      "0.9415030941737551", "", "",
      "0.02366831419883467", "0.18989476227180174", "0.43157318062118555",
      "0.6632020224193995", "0.860015542499582", "",
      "0.09056555904993387", "0.3078575723749043", "0.5516782402507934",
      "0.7652146863779808", "0.95247728378667541", "",
      "0.01677466677723562", "0.13902148819717805", "0.3325011117394731",
      "0.53766105314488", "0.7214184024215805", "0.8821858402078155",
      "0.06501319274445962", "0.23094129990840923", "0.4364942348420355",
      "0.06329609551399348", "0.80378086794111226", "0.9599687404800694",
      "0.23647102099689224", "", "", "", "", "",
      "0.7145421497126001", "", "", "", "", "",
      "0.12073211751675449", "0.6632020224193995", "", "", "", "",
      "0.3903621872345006", "0.890786832653497", "", "", "", "",
      "0.1271414136264853", "0.6528245886369117", "0.9176942834328115",
      "", "", "",
      "0.40056789819445626", "0.8204163891923343", "0.9763114515836773",
      "", "", "",
      "0.07711507983241622", "0.4820706250610472", "0.7968204713315797",
      "0.9412514277740471", "", "",
      "0.2659685265210946", "0.6651041532634957", "0.8841015085506159",
      "0.9820054141886075", "", "",
      "0.051457617441190984", "0.35978656070567017", "0.6725475931034693",
      "0.8590884928249939", "0.9540209867860787", "",
      "0.18621906251989334", "0.529951372847964", "0.7810257527489514",
      "0.9141815687605308", "0.985475023014907", "",
      "0.036681502163648017", "0.2746317593794541", "0.56109896978791948",
      "0.769741833862266", "0.8922608180038789", "0.962094548378084",
      "0.13654762463195771", "0.42313861743656667", "0.6775400499741616",
      "0.839889624849638", "0.9315419599631839", "0.9878163707328971"
   };

   order_type  cur_order;
   logic       cur_steep;
   state_type  x_hist [NUM_PATHS][2*MAX_STAGES];
   state_type  y_hist [NUM_PATHS][2*MAX_STAGES];
   state_type  b_delayed;
   sample_type expected_samples [$];

   function automatic longint clamp_bits(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // exact round half up of a decimal fraction into q0.18
   function automatic coef_type coef_from_text(input string text);
      longint unsigned digits;
      longint unsigned rem;
      longint unsigned quo;
      int pos;
      byte ch;
      digits = 0;
      quo = 0;
      pos = 0;
      if (text.len() >= 2 && text[0] == "0" && text[1] == ".") pos = 2;
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         digits = digits * 10;
         if (pos < text.len()) begin
            ch = text[pos];
            if (ch >= "0" && ch <= "9") begin
               digits += longint'(ch - "0");
               pos++;
            end
         end
      end
      rem = digits;
      for (int i = 0; i < COEF_BITS; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= DECIMAL_ONE) begin
            rem -= DECIMAL_ONE;
            quo |= 1;
         end
      end
      if (2 * rem >= DECIMAL_ONE) quo++;
      return coef_type'(quo);
   endfunction

   function automatic void clear_history();
      for (int p = 0; p < NUM_PATHS; p++) begin
         for (int k = 0; k < 2 * MAX_STAGES; k++) begin
            x_hist[p][k] = '0;
            y_hist[p][k] = '0;
         end
      end
      b_delayed = '0;
   endfunction

   function automatic longint run_cascade(input int path, input longint x_in,
                                          input int row, input int nsec);
      longint x;
      longint x2;
      longint y2;
      longint y;
      longint prod;
      coef_type a;
      x = x_in;
      for (int s = 0; s < nsec; s++) begin
         a = coef_from_text(coef_text[((int'(cur_steep) * NUM_ORDERS + row) * NUM_PATHS
                                       + path) * MAX_STAGES + s]);
         x2 = longint'(x_hist[path][2*s+1]);
         y2 = longint'(y_hist[path][2*s+1]);
         prod = (x - y2) * longint'(a);
         y = clamp_bits(x2 + ((prod + (64'sd1 <<< (COEF_BITS - 1))) >>> COEF_BITS),
                        STATE_BITS);
         x_hist[path][2*s+1] = x_hist[path][2*s];
         x_hist[path][2*s] = state_type'(x);
         y_hist[path][2*s+1] = y_hist[path][2*s];
         y_hist[path][2*s] = state_type'(y);
         x = y;
      end
      return x;
   endfunction

   function automatic sample_type filter_sample(input sample_type s);
      int row;
      int nsec;
      longint sum;
      case (cur_order)
         4'd4:    row = 1;
         4'd6:    row = 2;
         4'd8:    row = 3;
         4'd10:   row = 4;
         4'd12:   row = 5;
         default: row = 0;
      endcase
      nsec = (row + 1 > MAX_STAGES) ? MAX_STAGES : row + 1;
      sum = run_cascade(int'(PATH_A), longint'(s), row, nsec) + longint'(b_delayed);
      b_delayed = state_type'(run_cascade(int'(PATH_B), longint'(s), row, nsec));
      return sample_type'(clamp_bits((sum + 1) >>> 1, SAMPLE_BITS));
   endfunction

   always @(posedge clock) begin : watch
      sample_type want;
      if (reset) begin
         cur_order = ORDER_RESET;
         cur_steep = STEEP_RESET;
         clear_history();
         expected_samples.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FILTER_ORDER) begin
               cur_order = order_type'(csr_data);
               clear_history();
            end else if (csr_index == REG_STEEP_MODE) begin
               cur_steep = csr_data[0];
               clear_history();
            end
         end
         if (req_valid && req_ready) begin
            expected_samples.push_back(filter_sample(req_sample_in));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out: expected none, actual %0d", rsp_sample_out);
               mismatch_count++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out: expected %0d, actual %0d", want, rsp_sample_out);
                  mismatch_count++;
               end
            end
         end
      end
      pending_samples = expected_samples.size();
   end

endmodule

### dv/polyphase_iir_halfband_filter_core_test.sv
// top of the polyphase iir half-band filter core test: clock, reset, sample stimulus,
// csr phases over all orders and both coefficient sets, stalls and the verdict
// depends on phf_pkg, polyphase_iir_halfband_filter_core and halfband_output_checker
`timescale 1ns / 1ps

module polyphase_iir_halfband_filter_core_test;
   import phf_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 60;
   localparam int END_CYCLES    = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int NUM_PHASES    = 16;
   localparam int PHASE_ITEMS   = 56;
   localparam int HOLD_PHASE    = 13;
   localparam int NUM_CORNERS   = 20;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   sample_type                req_sample_in;
   logic                      rsp_valid;
   logic                      rsp_ready;
   sample_type                rsp_sample_out;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        mismatch_count;
   int                        pending_samples;

   int   send_idle_pct = 15;
   int   recv_idle_pct = 75;
   logic hold_request;
   int   cycle_count = 0;

   order_type  phase_order [NUM_PHASES] = '{4'd12, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd0,
                                            4'd15, 4'd4, 4'd6, 4'd8, 4'd10, 4'd2, 4'd12,
                                            4'd5, 4'd12};
   logic       phase_steep [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                            1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                            1'b1, 1'b0};
   sample_type corner_samples [NUM_CORNERS] = '{
      24'sh000000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
      24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
      24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000,
      24'sh000001, 24'shFFFFFF, 24'sh555555, 24'shAAAAAA, 24'sh000000
   };

   polyphase_iir_halfband_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   halfband_output_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .pending_samples (pending_samples)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls plus one long hold-off
   initial begin : receiver
      int   hold_left;
      logic hold_taken;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_sample(input sample_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_samples != 0) @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin : stimulus
      int kind;
      sample_type value;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample_in <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      hold_request <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (corner_samples[i]) send_sample(corner_samples[i]);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 6) begin
            send_idle_pct = 15;
            recv_idle_pct = 75;
         end else if (ph < 11) begin
            send_idle_pct = 75;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_idle(SETTLE_CYCLES);
         write_register(REG_FILTER_ORDER, phase_order[ph]);
         write_register(REG_STEEP_MODE, {3'($urandom), phase_steep[ph]});
         if (ph == HOLD_PHASE) hold_request <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // mid-phase: an ignored out-of-range write or a same-value rewrite
            if (i == PHASE_ITEMS / 2) begin
               wait_idle(SETTLE_CYCLES);
               if (ph % 2 == 1) begin
                  write_register(CSR_INDEX_BITS'($urandom_range(2**CSR_INDEX_BITS - 1,
                                                                int'(REG_STEEP_MODE) + 1)),
                                 CSR_DATA_BITS'($urandom));
               end else begin
                  write_register(REG_FILTER_ORDER, phase_order[ph]);
               end
            end
            kind = $urandom_range(9);
            case (kind)
               0:       value = 24'sh7FFFFF;
               1:       value = 24'sh800000;
               2, 3:    value = sample_type'(int'($urandom_range(511)) - 256);
               default: value = sample_type'($urandom());
            endcase
            send_sample(value);
         end
      end

      wait_idle(END_CYCLES);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
